[rtl/eps_pkg.sv]
// ----------------------------------------------------------------------------
// eps_pkg: shared types and constants for the ellipse paint and score block
// Payload structs, register indexes, arithmetic widths and the channel
// difference and saturating add helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eps_pkg;

  // Frame geometry
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned MAX_SIDE = 1024;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_SEMI_MAJOR = 3'd2,
    REG_SEMI_MINOR = 3'd3,
    REG_COS_ANGLE  = 3'd4,
    REG_SIN_ANGLE  = 3'd5,
    REG_FILL_COLOR = 3'd6
  } cfg_reg_e;

  // Arithmetic widths
  localparam int unsigned AX_W   = 10;              // semi-axis
  localparam int unsigned AX2_W  = 2 * AX_W;        // squared semi-axis
  localparam int unsigned AB2_W  = 2 * AX2_W;       // a^2 * b^2
  localparam int unsigned RHS_SH = 28;              // Q1.14 squared scale
  localparam int unsigned ROT_W  = 28;              // signed rotated coordinate
  localparam int unsigned SQ_W   = 2 * (ROT_W - 1); // squared magnitude
  localparam int unsigned ACC_W  = 75;              // left-hand sum
  localparam int unsigned MUL_W  = 33;              // multiplier operand
  localparam int unsigned PROD_W = 64;              // kept product bits
  localparam int unsigned DIFF_W = 10;              // summed channel difference

  // Input word
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [31:0]        canvas_pixel;
    logic [31:0]        target_pixel;
    logic               last_pixel;
  } pix_in_t;

  // Output word
  typedef struct packed {
    logic [31:0] painted_pixel;
    logic        covered;
    logic [31:0] score_painted;
    logic [31:0] score_unpainted;
    logic        improves;
  } pix_out_t;

  // Sum of absolute RGB channel differences, alpha ignored
  function automatic logic [DIFF_W-1:0] chan_diff(input logic [23:0] p,
                                                  input logic [23:0] q);
    logic [DIFF_W-1:0] s;
    logic [7:0]        a;
    logic [7:0]        b;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      a = p[8*i +: 8];
      b = q[8*i +: 8];
      s = s + DIFF_W'((a > b) ? (a - b) : (b - a));
    end
    return s;
  endfunction

  // Saturating 32-bit add of a channel difference
  function automatic logic [31:0] sat_add(input logic [31:0] s,
                                          input logic [DIFF_W-1:0] d);
    logic [32:0] r;
    r = {1'b0, s} + 33'(d);
    return r[32] ? 32'hFFFF_FFFF : r[31:0];
  endfunction

endpackage

[rtl/ellipse_paint_and_score.sv]
// ----------------------------------------------------------------------------
// ellipse_paint_and_score: rotated ellipse inside test with paint and score
// Tests each streamed pixel against a configured rotated ellipse, paints the
// covered ones and keeps two saturating difference sums for the frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel words enter on in_valid_i/in_ready_o and leave on
//   out_valid_o/out_ready_i, one output word per input word, in order.
//   The configuration registers are written through cfg_we_i, cfg_index_i and
//   cfg_wdata_i while no pixel is in flight; writes take effect at once.
//   An accepted pixel runs through a sequencer that drives one shared 33x33
//   signed multiplier: thirteen products (squared axes, rotation, squared
//   magnitudes and the split wide products) over steps 0 to 12, then a
//   finish cycle compares and updates the sums. The output word is
//   registered at the end of the finish cycle, and a new pixel is taken
//   only after the previous one has left the finish cycle.
//   A finished word sits in the output register until taken; the next pixel
//   is accepted meanwhile and its finish cycle waits while the register is
//   still full, so a stalled receiver holds the block without losing words.
//   Reset clears both sums, empties the output register and loads the
//   register defaults (unit circle, centre 0, fill black).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ellipse_paint_and_score (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [eps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [eps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  eps_pkg::pix_in_t           in_data_i,
  // pixel output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output eps_pkg::pix_out_t          out_data_o
);
  import eps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [3:0] LAST_STEP = 4'd13;

  // Configuration registers
  logic [COORD_W-1:0] center_x_q, center_y_q;
  logic [AX_W-1:0]    semi_major_q, semi_minor_q;
  logic signed [15:0] cos_q, sin_q;
  logic [23:0]        fill_q;

  // Control
  logic [1:0] state_q, state_d;
  logic [3:0] step_q;

  // Per-pixel working registers
  logic signed [COORD_W:0] xc_q, yc_q;
  logic                    boxed_q, last_q;
  logic [31:0]             canvas_q;
  logic [DIFF_W-1:0]       diff_fill_q, diff_canvas_q;
  logic [AX2_W-1:0]        a2_q, b2_q;
  logic signed [ROT_W-1:0] u_q, v_q;
  logic [SQ_W-1:0]         squ_q, sqv_q;
  logic [AB2_W-1:0]        ab2_q;
  logic [ACC_W-1:0]        acc_q;

  // Shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [PROD_W-1:0]         prod_q;

  // Sums and output register
  logic [31:0] psum_q, usum_q;
  logic        out_valid_q;
  pix_out_t    out_q;

  // Bounding box
  logic [AX_W-1:0]    bb;
  logic [COORD_W:0]   x0, x1, y0, y1;
  logic               boxed_in;

  // Finish-cycle results
  logic              covered;
  logic [DIFF_W-1:0] diff_sel;
  logic [31:0]       psum_new, usum_new;
  logic              out_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Box around the centre, lower edge clamped at zero, upper at the frame
  always_comb begin
    bb = (semi_major_q > semi_minor_q) ? semi_major_q : semi_minor_q;
    x0 = (center_x_q < bb) ? '0 : (COORD_W+1)'(center_x_q - bb);
    y0 = (center_y_q < bb) ? '0 : (COORD_W+1)'(center_y_q - bb);
    x1 = (COORD_W+1)'(center_x_q) + (COORD_W+1)'(bb);
    y1 = (COORD_W+1)'(center_y_q) + (COORD_W+1)'(bb);
    if (x1 > (COORD_W+1)'(MAX_SIDE)) x1 = (COORD_W+1)'(MAX_SIDE);
    if (y1 > (COORD_W+1)'(MAX_SIDE)) y1 = (COORD_W+1)'(MAX_SIDE);
    boxed_in = ((COORD_W+1)'(in_data_i.pixel_x) >= x0) &&
               ((COORD_W+1)'(in_data_i.pixel_x) <  x1) &&
               ((COORD_W+1)'(in_data_i.pixel_y) >= y0) &&
               ((COORD_W+1)'(in_data_i.pixel_y) <  y1);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      semi_major_q <= AX_W'(1);
      semi_minor_q <= AX_W'(1);
      cos_q        <= 16'sd16384;
      sin_q        <= '0;
      fill_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CENTER_X:   center_x_q   <= cfg_wdata_i[COORD_W-1:0];
        REG_CENTER_Y:   center_y_q   <= cfg_wdata_i[COORD_W-1:0];
        REG_SEMI_MAJOR: semi_major_q <= cfg_wdata_i[AX_W-1:0];
        REG_SEMI_MINOR: semi_minor_q <= cfg_wdata_i[AX_W-1:0];
        REG_COS_ANGLE:  cos_q        <= cfg_wdata_i[15:0];
        REG_SIN_ANGLE:  sin_q        <= cfg_wdata_i[15:0];
        REG_FILL_COLOR: fill_q       <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      4'd0:  begin mul_a = MUL_W'(semi_major_q); mul_b = MUL_W'(semi_major_q); end
      4'd1:  begin mul_a = MUL_W'(semi_minor_q); mul_b = MUL_W'(semi_minor_q); end
      4'd2:  begin mul_a = MUL_W'(xc_q);         mul_b = MUL_W'(cos_q);        end
      4'd3:  begin mul_a = MUL_W'(yc_q);         mul_b = MUL_W'(sin_q);        end
      4'd4:  begin mul_a = MUL_W'(xc_q);         mul_b = MUL_W'(sin_q);        end
      4'd5:  begin mul_a = MUL_W'(yc_q);         mul_b = MUL_W'(cos_q);        end
      4'd6:  begin mul_a = MUL_W'(u_q);          mul_b = MUL_W'(u_q);          end
      4'd7:  begin mul_a = MUL_W'(a2_q);         mul_b = MUL_W'(b2_q);         end
      4'd8:  begin mul_a = MUL_W'(v_q);          mul_b = MUL_W'(v_q);          end
      4'd9:  begin mul_a = MUL_W'(squ_q[31:0]);  mul_b = MUL_W'(b2_q);         end
      4'd10: begin mul_a = MUL_W'(squ_q[SQ_W-1:32]); mul_b = MUL_W'(b2_q);     end
      4'd11: begin mul_a = MUL_W'(sqv_q[31:0]);  mul_b = MUL_W'(a2_q);         end
      4'd12: begin mul_a = MUL_W'(sqv_q[SQ_W-1:32]); mul_b = MUL_W'(a2_q);     end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Register the product
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[PROD_W-1:0];
  end

  // Finish: inside test, paint and sum update
  always_comb begin
    covered  = boxed_q && (acc_q <= ACC_W'({ab2_q, {RHS_SH{1'b0}}}));
    diff_sel = covered ? diff_fill_q : diff_canvas_q;
    psum_new = boxed_q ? sat_add(psum_q, diff_sel)      : psum_q;
    usum_new = boxed_q ? sat_add(usum_q, diff_canvas_q) : usum_q;
    out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CALC;
      ST_CALC: if (step_q == LAST_STEP) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Advance the sequencer, hold the sums and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      psum_q      <= '0;
      usum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CALC) begin
        step_q <= step_q + 4'd1;
      end else begin
        step_q <= '0;
      end
      if (out_load) begin
        psum_q      <= last_q ? '0 : psum_new;
        usum_q      <= last_q ? '0 : usum_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the word, consume the previous step's product and load the output word
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      xc_q          <= $signed({1'b0, in_data_i.pixel_x}) - $signed({1'b0, center_x_q});
      yc_q          <= $signed({1'b0, in_data_i.pixel_y}) - $signed({1'b0, center_y_q});
      boxed_q       <= boxed_in;
      last_q        <= in_data_i.last_pixel;
      canvas_q      <= in_data_i.canvas_pixel;
      diff_fill_q   <= chan_diff(in_data_i.target_pixel[23:0], fill_q);
      diff_canvas_q <= chan_diff(in_data_i.target_pixel[23:0],
                                 in_data_i.canvas_pixel[23:0]);
    end
    if (state_q == ST_CALC) begin
      case (step_q)
        4'd1:  a2_q  <= prod_q[AX2_W-1:0];
        4'd2:  b2_q  <= prod_q[AX2_W-1:0];
        4'd3:  u_q   <= $signed(prod_q[ROT_W-1:0]);
        4'd4:  u_q   <= u_q - $signed(prod_q[ROT_W-1:0]);
        4'd5:  begin
          u_q <= u_q[ROT_W-1] ? -u_q : u_q;
          v_q <= $signed(prod_q[ROT_W-1:0]);
        end
        4'd6:  v_q   <= v_q + $signed(prod_q[ROT_W-1:0]);
        4'd7:  begin
          v_q   <= v_q[ROT_W-1] ? -v_q : v_q;
          squ_q <= prod_q[SQ_W-1:0];
        end
        4'd8:  ab2_q <= prod_q[AB2_W-1:0];
        4'd9:  sqv_q <= prod_q[SQ_W-1:0];
        4'd10: acc_q <= ACC_W'(prod_q);
        4'd11: acc_q <= acc_q + {prod_q[ACC_W-33:0], 32'b0};
        4'd12: acc_q <= acc_q + ACC_W'(prod_q);
        4'd13: acc_q <= acc_q + {prod_q[ACC_W-33:0], 32'b0};
        default: ;
      endcase
    end
    if (out_load) begin
      out_q.painted_pixel   <= covered ? {8'hFF, fill_q} : canvas_q;
      out_q.covered         <= covered;
      out_q.score_painted   <= psum_new;
      out_q.score_unpainted <= usum_new;
      out_q.improves        <= last_q && (psum_new < usum_new);
    end
  end

  // An accepted word starts the sequencer at its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CALC && step_q == 4'd0))
    else $error("sequencer did not start on an accepted word");

  // A new output word only comes out of the finish cycle
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("output word loaded outside the finish cycle");

  // A covered pixel carries the opaque fill
  a_paint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.covered) |-> (out_data_o.painted_pixel[31:24] == 8'hFF))
    else $error("covered pixel without opaque alpha");

  // Improvement only when the painted score is strictly lower
  a_improve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.improves) |->
      (out_data_o.score_painted < out_data_o.score_unpainted))
    else $error("improves flag disagrees with the scores");

endmodule
